@@ design/gbc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gbc_pkg;

    localparam int CAPACITY  = 1024;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 11;
    localparam int CP_W      = 21;
    localparam int OP_W      = 4;
    localparam int PHASE_W   = 3;

    localparam logic [CP_W-1:0] CH_NEWLINE = CP_W'(10);
    localparam logic [CP_W-1:0] CH_SPACE   = CP_W'(32);
    localparam logic [CP_W-1:0] CH_TAB     = CP_W'(9);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT      = 4'd0,
        OP_BACKSPACE   = 4'd1,
        OP_LEFT        = 4'd2,
        OP_RIGHT       = 4'd3,
        OP_NEXT_WORD   = 4'd4,
        OP_PREV_WORD   = 4'd5,
        OP_WORD_END    = 4'd6,
        OP_LINE_END    = 4'd7,
        OP_LINE_START  = 4'd8,
        OP_ABS_START   = 4'd9,
        OP_PREV_LINE   = 4'd10,
        OP_NEXT_LINE   = 4'd11
    } op_t;

    // One phase of a command: a single edit, a single step, or a walk that
    // repeats a step while its condition holds.
    typedef enum logic [3:0] {
        PH_DONE,
        PH_INS,
        PH_BKSP,
        PH_L_ONE,
        PH_R_ONE,
        PH_L_WORD,
        PH_L_NONWORD,
        PH_R_WORD,
        PH_R_NONWORD,
        PH_L_NL,
        PH_R_NL,
        PH_R_BLANK
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FILL,
        ST_DONE
    } state_t;

    function automatic logic is_word(input logic [CP_W-1:0] c);
        logic cls;
        cls = (c >= CP_W'(48) && c <= CP_W'(57)) ||
              (c >= CP_W'(65) && c <= CP_W'(90)) ||
              (c >= CP_W'(97) && c <= CP_W'(122)) ||
              (c >= CP_W'(192) && c <= CP_W'(687));
        return cls && (c != CP_W'(215)) && (c != CP_W'(247));
    endfunction

    function automatic logic is_blank(input logic [CP_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    // Microprogram: the phase that a command runs at a given index.
    function automatic phase_t phase_of(input logic [OP_W-1:0] op,
                                        input logic [PHASE_W-1:0] idx);
        phase_t ph;
        ph = PH_DONE;
        unique case (op)
            OP_INSERT:     ph = (idx == 3'd0) ? PH_INS : PH_DONE;
            OP_BACKSPACE:  ph = (idx == 3'd0) ? PH_BKSP : PH_DONE;
            OP_LEFT:       ph = (idx == 3'd0) ? PH_L_ONE : PH_DONE;
            OP_RIGHT:      ph = (idx == 3'd0) ? PH_R_ONE : PH_DONE;
            OP_NEXT_WORD:  ph = (idx == 3'd0) ? PH_R_WORD :
                                (idx == 3'd1) ? PH_R_NONWORD : PH_DONE;
            OP_PREV_WORD:  ph = (idx == 3'd0) ? PH_L_NONWORD :
                                (idx == 3'd1) ? PH_L_WORD : PH_DONE;
            OP_WORD_END:   ph = (idx == 3'd0) ? PH_R_NONWORD :
                                (idx == 3'd1) ? PH_R_WORD : PH_DONE;
            OP_LINE_END:   ph = (idx == 3'd0) ? PH_R_NL : PH_DONE;
            OP_LINE_START: ph = (idx == 3'd0) ? PH_L_NL :
                                (idx == 3'd1) ? PH_R_BLANK : PH_DONE;
            OP_ABS_START:  ph = (idx == 3'd0) ? PH_L_NL : PH_DONE;
            OP_PREV_LINE:  ph = (idx == 3'd0) ? PH_L_NL :
                                (idx == 3'd1) ? PH_L_ONE :
                                (idx == 3'd2) ? PH_L_NL :
                                (idx == 3'd3) ? PH_R_BLANK : PH_DONE;
            OP_NEXT_LINE:  ph = (idx == 3'd0) ? PH_R_NL :
                                (idx == 3'd1) ? PH_R_ONE :
                                (idx == 3'd2) ? PH_L_NL :
                                (idx == 3'd3) ? PH_R_BLANK : PH_DONE;
            default:       ph = PH_DONE;
        endcase
        return ph;
    endfunction

endpackage

`default_nettype wire

@@ design/gap_buffer_cursor_engine_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake          Payload
// s_       in         s_valid / s_ready  s_op, s_code_point
// m_       out        m_valid / m_ready  m_before_count, m_after_count,
//                                        m_char_before, m_char_after, m_full_res
//
// Each command runs the phases of its microprogram in order, then the DONE state; a walk
// phase takes a step for each character it carries, and each step or backspace that leaves
// the shrinking stack non-empty passes through FILL to refetch its top from the text RAM.
// The result and s_ready rise together: DONE loads the output register and enters IDLE.
// Reset clears the counts and the cached cursor characters; the RAM is not cleared.
// A stalled result sits in the output register while the next command runs.

module gap_buffer_cursor_engine_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [gbc_pkg::OP_W-1:0]      s_op,
    input  wire logic [gbc_pkg::CP_W-1:0]      s_code_point,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [gbc_pkg::OUT_CNT_W-1:0] m_before_count,
    output logic      [gbc_pkg::OUT_CNT_W-1:0] m_after_count,
    output logic      [gbc_pkg::CP_W-1:0]      m_char_before,
    output logic      [gbc_pkg::CP_W-1:0]      m_char_after,
    output logic                               m_full_res
);

    import gbc_pkg::*;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    before_reg, before_next;
    logic [CNT_W-1:0]    after_reg, after_next;
    logic [CP_W-1:0]     top_b_reg, top_b_next;
    logic [CP_W-1:0]     top_a_reg, top_a_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic                fill_b_reg, fill_b_next;
    logic                full_reg, full_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [CP_W-1:0]     cp_reg, cp_next;

    logic                out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]    out_before_reg, out_before_next;
    logic [CNT_W-1:0]    out_after_reg, out_after_next;
    logic [CP_W-1:0]     out_cb_reg, out_cb_next;
    logic [CP_W-1:0]     out_ca_reg, out_ca_next;
    logic                out_full_reg, out_full_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [CP_W-1:0]     ram_wdata, ram_rdata;

    logic [CNT_W:0]      total;
    phase_t              ph;
    logic                go_left, go_right, adv;

    gbc_ram #(
        .WIDTH(CP_W),
        .DEPTH(CAPACITY)
    ) u_text_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign total = {1'b0, before_reg} + {1'b0, after_reg};
    assign ph    = phase_of(op_reg, phase_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            before_reg    <= '0;
            after_reg     <= '0;
            top_b_reg     <= '0;
            top_a_reg     <= '0;
            phase_reg     <= '0;
            fill_b_reg    <= 1'b0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            before_reg    <= before_next;
            after_reg     <= after_next;
            top_b_reg     <= top_b_next;
            top_a_reg     <= top_a_next;
            phase_reg     <= phase_next;
            fill_b_reg    <= fill_b_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        cp_reg         <= cp_next;
        out_before_reg <= out_before_next;
        out_after_reg  <= out_after_next;
        out_cb_reg     <= out_cb_next;
        out_ca_reg     <= out_ca_next;
        out_full_reg   <= out_full_next;
    end

    always_comb begin
        state_next      = state_reg;
        before_next     = before_reg;
        after_next      = after_reg;
        top_b_next      = top_b_reg;
        top_a_next      = top_a_reg;
        phase_next      = phase_reg;
        fill_b_next     = fill_b_reg;
        full_next       = full_reg;
        op_next         = op_reg;
        cp_next         = cp_reg;
        out_valid_next  = out_valid_reg;
        out_before_next = out_before_reg;
        out_after_next  = out_after_reg;
        out_cb_next     = out_cb_reg;
        out_ca_next     = out_ca_reg;
        out_full_next   = out_full_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;
        go_left         = 1'b0;
        go_right        = 1'b0;
        adv             = 1'b0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_op;
                    cp_next    = s_code_point;
                    full_next  = 1'b0;
                    phase_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                unique case (ph)
                    PH_DONE: state_next = ST_DONE;
                    PH_INS: begin
                        adv = 1'b1;
                        if (total >= {1'b0, CAP_CNT}) begin
                            full_next = 1'b1;
                        end else begin
                            ram_we      = 1'b1;
                            ram_waddr   = ADDR_W'(before_reg);
                            ram_wdata   = cp_reg;
                            top_b_next  = cp_reg;
                            before_next = before_reg + CNT_W'(1);
                        end
                    end
                    PH_BKSP: begin
                        adv = 1'b1;
                        if (before_reg != '0) begin
                            before_next = before_reg - CNT_W'(1);
                            if (before_reg > CNT_W'(1)) begin
                                ram_raddr   = ADDR_W'(before_reg - CNT_W'(2));
                                fill_b_next = 1'b1;
                                state_next  = ST_FILL;
                            end else begin
                                top_b_next = '0;
                            end
                        end
                    end
                    PH_L_ONE: begin
                        adv     = 1'b1;
                        go_left = (before_reg != '0);
                    end
                    PH_R_ONE: begin
                        adv      = 1'b1;
                        go_right = (after_reg != '0);
                    end
                    PH_L_WORD: begin
                        go_left = (before_reg != '0) && is_word(top_b_reg);
                        adv     = !go_left;
                    end
                    PH_L_NONWORD: begin
                        go_left = (before_reg != '0) && !is_word(top_b_reg);
                        adv     = !go_left;
                    end
                    PH_R_WORD: begin
                        go_right = (after_reg != '0) && is_word(top_a_reg);
                        adv      = !go_right;
                    end
                    PH_R_NONWORD: begin
                        go_right = (after_reg != '0) && !is_word(top_a_reg);
                        adv      = !go_right;
                    end
                    PH_L_NL: begin
                        go_left = (before_reg != '0) && (top_b_reg != CH_NEWLINE);
                        adv     = !go_left;
                    end
                    PH_R_NL: begin
                        go_right = (after_reg != '0) && (top_a_reg != CH_NEWLINE);
                        adv      = !go_right;
                    end
                    PH_R_BLANK: begin
                        go_right = (after_reg != '0) && is_blank(top_a_reg);
                        adv      = !go_right;
                    end
                    default: state_next = ST_DONE;
                endcase

                // A step pushes the top of one stack onto the other, then the
                // shrinking stack's new top, if any, is fetched from the RAM.
                if (go_left) begin
                    ram_we      = 1'b1;
                    ram_waddr   = ADDR_W'(CAP_CNT - after_reg - CNT_W'(1));
                    ram_wdata   = top_b_reg;
                    top_a_next  = top_b_reg;
                    after_next  = after_reg + CNT_W'(1);
                    before_next = before_reg - CNT_W'(1);
                    if (before_reg > CNT_W'(1)) begin
                        ram_raddr   = ADDR_W'(before_reg - CNT_W'(2));
                        fill_b_next = 1'b1;
                        state_next  = ST_FILL;
                    end else begin
                        top_b_next = '0;
                    end
                end
                if (go_right) begin
                    ram_we      = 1'b1;
                    ram_waddr   = ADDR_W'(before_reg);
                    ram_wdata   = top_a_reg;
                    top_b_next  = top_a_reg;
                    before_next = before_reg + CNT_W'(1);
                    after_next  = after_reg - CNT_W'(1);
                    if (after_reg > CNT_W'(1)) begin
                        ram_raddr   = ADDR_W'(CAP_CNT - after_reg + CNT_W'(1));
                        fill_b_next = 1'b0;
                        state_next  = ST_FILL;
                    end else begin
                        top_a_next = '0;
                    end
                end
                if (adv) begin
                    phase_next = phase_reg + PHASE_W'(1);
                end
            end
            ST_FILL: begin
                if (fill_b_reg) begin
                    top_b_next = ram_rdata;
                end else begin
                    top_a_next = ram_rdata;
                end
                state_next = ST_RUN;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next  = 1'b1;
                    out_before_next = before_reg;
                    out_after_next  = after_reg;
                    out_cb_next     = top_b_reg;
                    out_ca_next     = top_a_reg;
                    out_full_next   = full_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = out_valid_reg;
    assign m_before_count = OUT_CNT_W'(out_before_reg);
    assign m_after_count  = OUT_CNT_W'(out_after_reg);
    assign m_char_before  = out_cb_reg;
    assign m_char_after   = out_ca_reg;
    assign m_full_res     = out_full_reg;

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total <= {1'b0, CAP_CNT})
        else $error("text length exceeds capacity");

    a_empty_before: assert property (@(posedge aclk) disable iff (!aresetn)
        (before_reg == '0) |-> (top_b_reg == '0))
        else $error("character before cursor cached with empty front stack");

    a_empty_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (after_reg == '0) |-> (top_a_reg == '0))
        else $error("character after cursor cached with empty back stack");

    a_fill_follows_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL) |-> ($past(state_reg) == ST_RUN))
        else $error("RAM fill cycle without a preceding step");

    a_full_only_at_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_full_reg) |->
            (({1'b0, out_before_reg} + {1'b0, out_after_reg}) == {1'b0, CAP_CNT}))
        else $error("refused insert reported while store not full");

endmodule

`default_nettype wire

@@ design/gbc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gbc_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ dv/gap_buffer_scoreboard.sv @@
`timescale 1ns / 1ps

module gap_buffer_scoreboard (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire logic [gbc_pkg::OP_W-1:0]      s_op,
    input  wire logic [gbc_pkg::CP_W-1:0]      s_code_point,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic [gbc_pkg::OUT_CNT_W-1:0] m_before_count,
    input  wire logic [gbc_pkg::OUT_CNT_W-1:0] m_after_count,
    input  wire logic [gbc_pkg::CP_W-1:0]      m_char_before,
    input  wire logic [gbc_pkg::CP_W-1:0]      m_char_after,
    input  wire logic                          m_full_res,
    output int                                 fail_count,
    output int                                 pending_results
);

    import gbc_pkg::*;

    localparam int WORD_EXT_LO = 192;
    localparam int WORD_EXT_HI = 687;
    localparam int TIMES_SIGN  = 215;
    localparam int DIVIDE_SIGN = 247;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] before_cnt;
        logic [OUT_CNT_W-1:0] after_cnt;
        logic [CP_W-1:0]      left_cp;
        logic [CP_W-1:0]      right_cp;
        logic                 refused;
    } cursor_status_t;

    // Text left of the cursor fills upward from entry 0; text right of it
    // fills downward from the top entry.
    logic [CP_W-1:0] text_mem [0:CAPACITY-1];
    int unsigned     left_len;
    int unsigned     right_len;

    cursor_status_t  expected_status [$];

    function automatic bit word_char(input logic [CP_W-1:0] c);
        bit alnum;
        alnum = (c >= 48 && c <= 57) || (c >= 65 && c <= 90) || (c >= 97 && c <= 122);
        if (c == TIMES_SIGN || c == DIVIDE_SIGN) begin
            return 1'b0;
        end
        return alnum || (c >= WORD_EXT_LO && c <= WORD_EXT_HI);
    endfunction

    function automatic bit blank_char(input logic [CP_W-1:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic logic [CP_W-1:0] char_left();
        return (left_len > 0) ? text_mem[left_len - 1] : '0;
    endfunction

    function automatic logic [CP_W-1:0] char_right();
        return (right_len > 0) ? text_mem[CAPACITY - right_len] : '0;
    endfunction

    function automatic void move_left();
        logic [CP_W-1:0] c;
        if (left_len == 0 || right_len >= CAPACITY) begin
            return;
        end
        c = text_mem[left_len - 1];
        left_len--;
        right_len++;
        text_mem[CAPACITY - right_len] = c;
    endfunction

    function automatic void move_right();
        logic [CP_W-1:0] c;
        if (right_len == 0 || left_len >= CAPACITY) begin
            return;
        end
        c = text_mem[CAPACITY - right_len];
        right_len--;
        text_mem[left_len] = c;
        left_len++;
    endfunction

    function automatic void seek_line_head();
        while (left_len > 0 && char_left() != CH_NEWLINE) move_left();
    endfunction

    function automatic void seek_line_tail();
        while (right_len > 0 && char_right() != CH_NEWLINE) move_right();
    endfunction

    function automatic void seek_indent_end();
        seek_line_head();
        while (right_len > 0 && blank_char(char_right())) move_right();
    endfunction

    function automatic cursor_status_t apply_command(input logic [OP_W-1:0] op,
                                                     input logic [CP_W-1:0] cp);
        cursor_status_t r;
        r.refused = 1'b0;
        case (op)
            OP_INSERT: begin
                if (left_len + right_len >= CAPACITY) begin
                    r.refused = 1'b1;
                end else begin
                    text_mem[left_len] = cp;
                    left_len++;
                end
            end
            OP_BACKSPACE: begin
                if (left_len > 0) begin
                    left_len--;
                end
            end
            OP_LEFT:  move_left();
            OP_RIGHT: move_right();
            OP_NEXT_WORD: begin
                while (right_len > 0 && word_char(char_right())) move_right();
                while (right_len > 0 && !word_char(char_right())) move_right();
            end
            OP_PREV_WORD: begin
                while (left_len > 0 && !word_char(char_left())) move_left();
                while (left_len > 0 && word_char(char_left())) move_left();
            end
            OP_WORD_END: begin
                while (right_len > 0 && !word_char(char_right())) move_right();
                while (right_len > 0 && word_char(char_right())) move_right();
            end
            OP_LINE_END:   seek_line_tail();
            OP_LINE_START: seek_indent_end();
            OP_ABS_START:  seek_line_head();
            OP_PREV_LINE: begin
                seek_line_head();
                move_left();
                seek_indent_end();
            end
            OP_NEXT_LINE: begin
                seek_line_tail();
                move_right();
                seek_indent_end();
            end
            default: ;
        endcase
        r.before_cnt = left_len[OUT_CNT_W-1:0];
        r.after_cnt  = right_len[OUT_CNT_W-1:0];
        r.left_cp    = char_left();
        r.right_cp   = char_right();
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned seen);
        if (want != seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        cursor_status_t want;
        if (!aresetn) begin
            expected_status.delete();
            left_len = 0;
            right_len = 0;
        end else begin
            // Compare before predicting, so a result never matches a command
            // accepted on the same edge.
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    $error("result word arrived with no command outstanding");
                    fail_count++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("before_count", want.before_cnt, m_before_count);
                    check_field("after_count", want.after_cnt, m_after_count);
                    check_field("char_before", want.left_cp, m_char_before);
                    check_field("char_after", want.right_cp, m_char_after);
                    check_field("full_res", want.refused, m_full_res);
                end
            end
            if (s_valid && s_ready) begin
                expected_status.push_back(apply_command(s_op, s_code_point));
            end
        end
        pending_results <= expected_status.size();
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import gbc_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd12;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;
    localparam int MAX_CP = 1114111;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [OP_W-1:0]      s_op = '0;
    logic [CP_W-1:0]      s_code_point = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [OUT_CNT_W-1:0] m_before_count;
    logic [OUT_CNT_W-1:0] m_after_count;
    logic [CP_W-1:0]      m_char_before;
    logic [CP_W-1:0]      m_char_after;
    logic                 m_full_res;

    int fail_count;
    int pending_results;
    int burst_left = 0;
    int stall_mode = 0;
    int mode_left = 0;

    // Characters on either side of each word-class boundary, plus the range ends.
    int boundary_cp [24] = '{47, 48, 57, 58, 64, 65, 90, 91, 96, 97, 122, 123,
                             191, 192, 214, 215, 216, 246, 247, 248, 687, 688,
                             0, MAX_CP};

    gap_buffer_cursor_engine_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_code_point   (s_code_point),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_before_count (m_before_count),
        .m_after_count  (m_after_count),
        .m_char_before  (m_char_before),
        .m_char_after   (m_char_after),
        .m_full_res     (m_full_res)
    );

    gap_buffer_scoreboard scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_code_point    (s_code_point),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_before_count  (m_before_count),
        .m_after_count   (m_after_count),
        .m_char_before   (m_char_before),
        .m_char_after    (m_char_after),
        .m_full_res      (m_full_res),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #200_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // The receiver switches between free flow, light and heavy back-pressure.
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 7) != 0);
            default: m_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    function automatic logic [CP_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return CP_W'($urandom_range(97, 122));
        if (r < 36) return CP_W'($urandom_range(65, 90));
        if (r < 40) return CP_W'($urandom_range(48, 57));
        if (r < 55) return CH_SPACE;
        if (r < 60) return CH_TAB;
        if (r < 70) return CH_NEWLINE;
        if (r < 80) return CP_W'($urandom_range(33, 126));
        if (r < 90) return CP_W'(boundary_cp[$urandom_range(0, 23)]);
        return CP_W'($urandom_range(0, MAX_CP));
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int insert_pct, input int erase_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < insert_pct) return OP_INSERT;
        if (r < insert_pct + erase_pct) return OP_BACKSPACE;
        if ($urandom_range(0, 49) == 0) begin
            return OP_W'($urandom_range(int'(OP_UNUSED_LO), int'(OP_UNUSED_HI)));
        end
        return OP_W'($urandom_range(int'(OP_LEFT), int'(OP_NEXT_LINE)));
    endfunction

    // Valid stays high across a burst; it drops only when a gap follows.
    task automatic issue(input logic [OP_W-1:0] op, input logic [CP_W-1:0] cp);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_op <= op;
        s_code_point <= cp;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic random_phase(input int count, input int insert_pct, input int erase_pct);
        logic [OP_W-1:0] op;
        for (int i = 0; i < count; i++) begin
            op = pick_op(insert_pct, erase_pct);
            issue(op, (op == OP_INSERT) ? pick_char() : CP_W'($urandom_range(0, MAX_CP)));
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Backspace, single steps and some walks on an empty store, plus an unused code.
        issue(OP_BACKSPACE, '0);
        issue(OP_LEFT, '0);
        issue(OP_RIGHT, '0);
        issue(OP_NEXT_WORD, '0);
        issue(OP_PREV_LINE, '0);
        issue(OP_NEXT_LINE, '0);
        issue(OP_UNUSED_HI, CP_W'(MAX_CP));

        issue(OP_INSERT, CP_W'(MAX_CP));
        issue(OP_INSERT, '0);
        issue(OP_INSERT, CH_NEWLINE);
        issue(OP_INSERT, CH_TAB);
        issue(OP_INSERT, CH_SPACE);
        issue(OP_INSERT, CP_W'(97));
        issue(OP_INSERT, CP_W'(687));
        issue(OP_INSERT, CP_W'(215));
        issue(OP_INSERT, CP_W'(192));
        issue(OP_INSERT, CH_NEWLINE);
        issue(OP_INSERT, CP_W'(90));

        issue(OP_PREV_LINE, '0);
        issue(OP_WORD_END, '0);
        issue(OP_NEXT_LINE, '0);
        issue(OP_PREV_WORD, '0);
        issue(OP_LINE_END, '0);
        issue(OP_ABS_START, '0);
        issue(OP_LINE_START, '0);
        issue(OP_UNUSED_LO, '0);

        // Editing of a growing text, then filling past capacity so inserts
        // get refused, then editing around a full store.
        random_phase(600, 40, 8);
        random_phase(1000, 95, 0);
        random_phase(200, 30, 10);

        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_results != 0);
        repeat (200) @(negedge aclk);

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
